### hdl/audio_pulse_latency_meter_macros.svh
// assertion macros for the pulse latency meter
`ifndef AUDIO_PULSE_LATENCY_METER_MACROS_SVH
`define AUDIO_PULSE_LATENCY_METER_MACROS_SVH

// same-cycle implication, quiet during reset
`define APL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apl: same-cycle check failed");

// next-cycle implication, quiet during reset
`define APL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apl: next-cycle check failed");

`endif

### hdl/apl_pkg.sv
// package: widths, codes, lane structs and the pulse shape table
`timescale 1ns / 1ps
package apl_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int TIME_W       = 17;
    localparam int LAT_W        = 18;
    localparam int DELAY_W      = 16;
    localparam int HIGH_W       = 15;
    localparam int CH_CNT_W     = 3;
    localparam int NUM_LANES    = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;
    localparam int TABLE_SIZE   = 64;
    localparam int TBL_IDX_W    = $clog2(TABLE_SIZE);
    localparam int PULSE_LEN_DEF = 64;

    localparam logic [DELAY_W-1:0]         RST_START_DELAY = 16'd128;
    localparam logic [TIME_W-1:0]          RST_TIMEOUT     = 17'd48000;
    localparam logic signed [SAMPLE_W-1:0] RST_LOW_TH      = -16'sd328;
    localparam logic [HIGH_W-1:0]          RST_HIGH_TH     = 15'd328;
    localparam logic [CH_CNT_W-1:0]        RST_CHANNELS    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY   = 3'd0,
        CFG_TIMEOUT       = 3'd1,
        CFG_LOW_TH        = 3'd2,
        CFG_HIGH_TH       = 3'd3,
        CFG_CHANNELS      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DELAY   = 2'd1,
        PH_MEASURE = 2'd2
    } t_phase;

    typedef struct packed {
        logic seed;     // first measuring tick: lanes start from the thresholds
        logic process;  // accepted sample tick while measuring
        logic clear;    // arm drops every lane
    } t_lane_ctrl;

    typedef struct packed {
        logic              active;
        logic              both_seen;
        logic [TIME_W-1:0] min_time;
        logic [TIME_W-1:0] max_time;
    } t_lane_status;

    localparam logic signed [SAMPLE_W-1:0] PULSE_TABLE [TABLE_SIZE] = '{
        16'sd0, 16'sd8, 16'sd61, 16'sd205, 16'sd477, 16'sd912, 16'sd1534, 16'sd2359,
        16'sd3393, 16'sd4630, 16'sd6054, 16'sd7638, 16'sd9344, 16'sd11127, 16'sd12934,
        16'sd14707, 16'sd16384, 16'sd17903, 16'sd19204, 16'sd20230, 16'sd20929,
        16'sd21261, 16'sd21191, 16'sd20700, 16'sd19777, 16'sd18428, 16'sd16671,
        16'sd14535, 16'sd12063, 16'sd9307, 16'sd6331, 16'sd3204,
        16'sd0, -16'sd3204, -16'sd6331, -16'sd9307, -16'sd12063, -16'sd14535,
        -16'sd16671, -16'sd18428, -16'sd19777, -16'sd20700, -16'sd21191, -16'sd21261,
        -16'sd20929, -16'sd20230, -16'sd19204, -16'sd17903, -16'sd16384, -16'sd14707,
        -16'sd12934, -16'sd11127, -16'sd9344, -16'sd7638, -16'sd6054, -16'sd4630,
        -16'sd3393, -16'sd2359, -16'sd1534, -16'sd912, -16'sd477, -16'sd205,
        -16'sd61, -16'sd8
    };

    // positions past the table play silence
    function automatic logic signed [SAMPLE_W-1:0] pulse_sample(input logic [15:0] pos);
        logic signed [SAMPLE_W-1:0] v;
        v = '0;
        if (pos < 16'(TABLE_SIZE)) begin
            v = PULSE_TABLE[pos[TBL_IDX_W-1:0]];
        end
        return v;
    endfunction

endpackage

### hdl/apl_lane.sv
// one receive channel: running extremes with timestamps and finish detection
`timescale 1ns / 1ps
module apl_lane
    import apl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctrl                 i_ctrl,
    input  logic                       i_enabled,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_low_th,
    input  logic [HIGH_W-1:0]          i_high_th,
    input  logic [TIME_W-1:0]          i_elapsed,
    output t_lane_status               o_status
);

    logic                       r_active, n_active;
    logic                       r_min_seen, n_min_seen;
    logic                       r_max_seen, n_max_seen;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic [TIME_W-1:0]          r_min_time, n_min_time;
    logic [TIME_W-1:0]          r_max_time, n_max_time;
    logic                       w_act_proc;

    always_comb begin
        n_active   = r_active;
        n_min_seen = r_min_seen;
        n_max_seen = r_max_seen;
        n_min      = r_min;
        n_max      = r_max;
        n_min_time = r_min_time;
        n_max_time = r_max_time;
        if (i_ctrl.seed) begin
            n_active   = i_enabled;
            n_min_seen = 1'b0;
            n_max_seen = 1'b0;
            n_min      = i_low_th;
            n_max      = signed'({1'b0, i_high_th});
            n_min_time = '0;
            n_max_time = '0;
        end
        if (i_ctrl.process && n_active) begin
            // new minimum wins over new maximum, finish only when neither
            if (i_sample < n_min) begin
                n_min      = i_sample;
                n_min_time = i_elapsed;
                n_min_seen = 1'b1;
            end else if (i_sample > n_max) begin
                n_max      = i_sample;
                n_max_time = i_elapsed;
                n_max_seen = 1'b1;
            end else if (n_min_seen && n_max_seen) begin
                n_active = 1'b0;
            end
        end
        w_act_proc = n_active;
        if (i_ctrl.clear) begin
            n_active = 1'b0;
        end
    end

    // a found lane took no update this tick, so the stored times are the ones
    assign o_status = '{active:    w_act_proc,
                        both_seen: n_min_seen && n_max_seen,
                        min_time:  r_min_time,
                        max_time:  r_max_time};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_min_seen <= 1'b0;
            r_max_seen <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_min_seen <= n_min_seen;
            r_max_seen <= n_max_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min      <= n_min;
        r_max      <= n_max;
        r_min_time <= n_min_time;
        r_max_time <= n_max_time;
    end

endmodule

### hdl/apl_merge.sv
// merges lane results: completion, found mask and latency per channel
`timescale 1ns / 1ps
module apl_merge
    import apl_pkg::*;
#(
    parameter int PULSE_LEN = PULSE_LEN_DEF,
    parameter int CHANNELS  = NUM_LANES
) (
    input  t_lane_status            i_status [NUM_LANES],
    input  logic [CH_CNT_W-1:0]     i_channels,
    input  logic                    i_done,
    output logic                    o_complete,
    output logic [NUM_LANES-1:0]    o_mask,
    output logic [LAT_W-1:0]        o_latency [NUM_LANES]
);

    localparam logic [LAT_W-1:0] CENTRE = LAT_W'(PULSE_LEN / 2);

    logic [NUM_LANES-1:0] w_active;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_ch
        logic [TIME_W:0]   w_sum;
        logic [TIME_W-1:0] w_avg;

        assign w_sum = {1'b0, i_status[c].min_time} + {1'b0, i_status[c].max_time};
        assign w_avg = w_sum[TIME_W:1];

        if (c < CHANNELS) begin : g_on
            assign w_active[c] = i_status[c].active;
            assign o_mask[c]   = i_done && (CH_CNT_W'(c) < i_channels)
                                 && !i_status[c].active && i_status[c].both_seen;
        end else begin : g_off
            assign w_active[c] = 1'b0;
            assign o_mask[c]   = 1'b0;
        end

        assign o_latency[c] = o_mask[c] ? (LAT_W'(w_avg) - CENTRE) : '0;
    end

    assign o_complete = ~|w_active;

endmodule

### hdl/apl_seq.sv
// measurement sequencer: phase, start delay, pulse playback and elapsed ticks
`timescale 1ns / 1ps
module apl_seq
    import apl_pkg::*;
#(
    parameter int PULSE_LEN = PULSE_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_mode,
    input  logic [DELAY_W-1:0]         i_start_delay,
    input  logic [TIME_W-1:0]          i_timeout,
    input  logic                       i_complete,
    output t_lane_ctrl                 o_ctrl,
    output logic [TIME_W-1:0]          o_elapsed,
    output logic signed [SAMPLE_W-1:0] o_tx,
    output logic                       o_done
);

    localparam int POS_W = $clog2(PULSE_LEN + 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(PULSE_LEN);

    t_phase             r_phase, n_phase, w_run_phase;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [POS_W-1:0]   r_pos, n_pos, w_run_pos;
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic [POS_W-1:0]   w_pos;
    logic               w_seed, w_meas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_delay   <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_delay   <= n_delay;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
        end
    end

    always_comb begin
        w_run_phase = r_phase;
        n_delay     = r_delay;
        w_run_pos   = r_pos;
        n_elapsed   = r_elapsed;
        w_seed      = 1'b0;
        w_meas      = 1'b0;
        o_tx        = '0;
        o_ctrl      = '0;
        if (i_fire) begin
            if (i_mode) begin
                w_run_phase  = PH_DELAY;
                n_delay      = i_start_delay;
                w_run_pos    = POS_END;
                o_ctrl.clear = 1'b1;
            end else begin
                case (r_phase)
                    PH_DELAY: begin
                        if (r_delay == '0) begin
                            w_seed = 1'b1;
                            w_meas = 1'b1;
                        end else begin
                            n_delay = r_delay - 1'b1;
                        end
                    end
                    PH_MEASURE: begin
                        w_meas = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
        w_pos     = w_seed ? '0 : r_pos;
        o_elapsed = w_seed ? '0 : r_elapsed;
        if (w_meas) begin
            w_run_phase = PH_MEASURE;
            if (w_pos < POS_END) begin
                o_tx      = pulse_sample(16'(w_pos));
                w_run_pos = w_pos + 1'b1;
            end else begin
                w_run_pos = w_pos;
            end
            n_elapsed      = o_elapsed + 1'b1;
            o_ctrl.seed    = w_seed;
            o_ctrl.process = 1'b1;
        end
    end

    // lanes are reseeded on the next pulse start, so the end needs no lane clear
    assign o_done = w_meas && (i_complete || (o_elapsed >= i_timeout));

    always_comb begin
        n_phase = w_run_phase;
        n_pos   = w_run_pos;
        if (o_done) begin
            n_phase = PH_IDLE;
            n_pos   = POS_END;
        end
    end

endmodule

### hdl/audio_pulse_latency_meter.sv
// top level: config registers, sequencer, receive lanes, merge and output register
// one beat in and one result beat out per cycle unless stalled; every item
// finishes in the cycle it is accepted; the output register shows it the next cycle
// sustained rate one item per clock while not stalled, set by the lane update
// synchronous active-low reset: idle phase, lanes inactive, registers at defaults
// no clearing pass: items are taken from the first cycle after reset
`timescale 1ns / 1ps
`include "audio_pulse_latency_meter_macros.svh"
module audio_pulse_latency_meter
    import apl_pkg::*;
#(
    parameter int PULSE_LEN = PULSE_LEN_DEF,
    parameter int CHANNELS  = NUM_LANES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic signed [SAMPLE_W-1:0]   i_rx_sample_0,
    input  logic signed [SAMPLE_W-1:0]   i_rx_sample_1,
    input  logic signed [SAMPLE_W-1:0]   i_rx_sample_2,
    input  logic signed [SAMPLE_W-1:0]   i_rx_sample_3,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SAMPLE_W-1:0]   o_tx_sample,
    output logic                         o_done_res,
    output logic [NUM_LANES-1:0]         o_found_mask,
    output logic signed [LAT_W-1:0]      o_latency_0,
    output logic signed [LAT_W-1:0]      o_latency_1,
    output logic signed [LAT_W-1:0]      o_latency_2,
    output logic signed [LAT_W-1:0]      o_latency_3,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    logic [DELAY_W-1:0]         r_start_delay;
    logic [TIME_W-1:0]          r_timeout;
    logic signed [SAMPLE_W-1:0] r_low_th;
    logic [HIGH_W-1:0]          r_high_th;
    logic [CH_CNT_W-1:0]        r_channels;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_tx;
    logic                       r_done;
    logic [NUM_LANES-1:0]       r_mask;
    logic [LAT_W-1:0]           r_lat [NUM_LANES];

    logic                       w_fire;
    t_lane_ctrl                 w_ctrl;
    logic [TIME_W-1:0]          w_elapsed;
    logic signed [SAMPLE_W-1:0] w_tx;
    logic                       w_done;
    logic                       w_complete;
    logic [NUM_LANES-1:0]       w_mask;
    logic [LAT_W-1:0]           w_lat [NUM_LANES];
    logic signed [SAMPLE_W-1:0] w_rx [NUM_LANES];
    t_lane_status               w_status [NUM_LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay <= RST_START_DELAY;
            r_timeout     <= RST_TIMEOUT;
            r_low_th      <= RST_LOW_TH;
            r_high_th     <= RST_HIGH_TH;
            r_channels    <= RST_CHANNELS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_DELAY: r_start_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data[TIME_W-1:0];
                CFG_LOW_TH:      r_low_th      <= signed'(i_cfg_data[SAMPLE_W-1:0]);
                CFG_HIGH_TH:     r_high_th     <= i_cfg_data[HIGH_W-1:0];
                CFG_CHANNELS:    r_channels    <= i_cfg_data[CH_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register frees itself when its beat is taken
    assign o_stall = r_out_valid && i_stall;
    assign w_fire  = i_valid && !o_stall;

    assign w_rx[0] = i_rx_sample_0;
    assign w_rx[1] = i_rx_sample_1;
    assign w_rx[2] = i_rx_sample_2;
    assign w_rx[3] = i_rx_sample_3;

    apl_seq #(
        .PULSE_LEN (PULSE_LEN)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_mode        (i_mode),
        .i_start_delay (r_start_delay),
        .i_timeout     (r_timeout),
        .i_complete    (w_complete),
        .o_ctrl        (w_ctrl),
        .o_elapsed     (w_elapsed),
        .o_tx          (w_tx),
        .o_done        (w_done)
    );

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            apl_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_enabled (CH_CNT_W'(c) < r_channels),
                .i_sample  (w_rx[c]),
                .i_low_th  (r_low_th),
                .i_high_th (r_high_th),
                .i_elapsed (w_elapsed),
                .o_status  (w_status[c])
            );
        end else begin : g_off
            assign w_status[c] = '0;
        end
    end

    apl_merge #(
        .PULSE_LEN (PULSE_LEN),
        .CHANNELS  (CHANNELS)
    ) u_merge (
        .i_status   (w_status),
        .i_channels (r_channels),
        .i_done     (w_done),
        .o_complete (w_complete),
        .o_mask     (w_mask),
        .o_latency  (w_lat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_tx   <= w_tx;
            r_done <= w_done;
            r_mask <= w_mask;
            r_lat  <= w_lat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tx_sample  = r_tx;
    assign o_done_res   = r_done;
    assign o_found_mask = r_mask;
    assign o_latency_0  = signed'(r_lat[0]);
    assign o_latency_1  = signed'(r_lat[1]);
    assign o_latency_2  = signed'(r_lat[2]);
    assign o_latency_3  = signed'(r_lat[3]);

    `APL_ASSERT_NOW(a_mask_only_on_done, i_clk, i_rst_n, r_out_valid && !r_done, r_mask == '0)
    `APL_ASSERT_NEXT(a_arm_beat_silent, i_clk, i_rst_n, w_fire && i_mode, r_tx == '0 && !r_done)
    `APL_ASSERT_NOW(a_seed_on_tick, i_clk, i_rst_n, w_ctrl.seed, w_fire && !i_mode)

endmodule

### tb/sv/tb.sv
// self-checking testbench for the audio pulse latency meter
`timescale 1ns / 1ps
module tb;
    import apl_pkg::*;

    localparam int PULSE_SPAN   = 64;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 500;
    localparam int CALM_FROM    = 1300;
    localparam int TOTAL_BEATS  = 1550;

    // windowed sine pulse, positive half then negated mirror
    localparam int SHAPE [PULSE_SPAN] = '{
        0, 8, 61, 205, 477, 912, 1534, 2359,
        3393, 4630, 6054, 7638, 9344, 11127, 12934, 14707,
        16384, 17903, 19204, 20230, 20929, 21261, 21191, 20700,
        19777, 18428, 16671, 14535, 12063, 9307, 6331, 3204,
        0, -3204, -6331, -9307, -12063, -14535, -16671, -18428,
        -19777, -20700, -21191, -21261, -20929, -20230, -19204, -17903,
        -16384, -14707, -12934, -11127, -9344, -7638, -6054, -4630,
        -3393, -2359, -1534, -912, -477, -205, -61, -8
    };

    typedef struct packed {
        logic [15:0]      tx;
        logic             done;
        logic [3:0]       mask;
        logic [3:0][17:0] lat;
    } t_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_mode;
    logic signed [SAMPLE_W-1:0] i_rx_sample_0;
    logic signed [SAMPLE_W-1:0] i_rx_sample_1;
    logic signed [SAMPLE_W-1:0] i_rx_sample_2;
    logic signed [SAMPLE_W-1:0] i_rx_sample_3;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_tx_sample;
    logic                       o_done_res;
    logic [NUM_LANES-1:0]       o_found_mask;
    logic signed [LAT_W-1:0]    o_latency_0;
    logic signed [LAT_W-1:0]    o_latency_1;
    logic signed [LAT_W-1:0]    o_latency_2;
    logic signed [LAT_W-1:0]    o_latency_3;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    audio_pulse_latency_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_rx_sample_0 (i_rx_sample_0),
        .i_rx_sample_1 (i_rx_sample_1),
        .i_rx_sample_2 (i_rx_sample_2),
        .i_rx_sample_3 (i_rx_sample_3),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_sample   (o_tx_sample),
        .o_done_res    (o_done_res),
        .o_found_mask  (o_found_mask),
        .o_latency_0   (o_latency_0),
        .o_latency_1   (o_latency_1),
        .o_latency_2   (o_latency_2),
        .o_latency_3   (o_latency_3),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // register shadow
    logic [15:0]        cfg_start_delay;
    logic [16:0]        cfg_timeout;
    logic signed [15:0] cfg_low;
    logic [14:0]        cfg_high;
    logic [2:0]         cfg_chans;

    // meter state
    logic [31:0]        tick_count;
    t_phase             meter_phase;
    logic [15:0]        hold_count;
    int                 tone_pos;
    logic [31:0]        pulse_t0;
    logic               lane_live    [4];
    logic signed [15:0] lane_min     [4];
    logic signed [15:0] lane_max     [4];
    logic [31:0]        lane_tmin    [4];
    logic [31:0]        lane_tmax    [4];
    logic               lane_has_min [4];
    logic               lane_has_max [4];

    t_report report_q [$];

    int  beats_in;
    int  beats_out;
    int  reports_done;
    int  reg_writes;
    int  mismatches;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_req;

    function automatic void meter_reset();
        cfg_start_delay = 16'd128;
        cfg_timeout     = 17'd48000;
        cfg_low         = -16'sd328;
        cfg_high        = 15'd328;
        cfg_chans       = 3'd4;
        tick_count      = '0;
        meter_phase     = PH_IDLE;
        hold_count      = '0;
        tone_pos        = 0;
        pulse_t0        = '0;
        for (int c = 0; c < 4; c++) begin
            lane_live[c]    = 1'b0;
            lane_min[c]     = '0;
            lane_max[c]     = '0;
            lane_tmin[c]    = '0;
            lane_tmax[c]    = '0;
            lane_has_min[c] = 1'b0;
            lane_has_max[c] = 1'b0;
        end
    endfunction

    // one tick of the meter: returns the report that the beat causes
    function automatic t_report meter_advance(input logic arm, input logic [3:0][15:0] rx);
        t_report            r;
        logic               all_quiet;
        logic signed [15:0] v;
        logic [32:0]        avg;
        int                 n;
        r = '0;
        n = (cfg_chans > 3'd4) ? 4 : int'(cfg_chans);
        if (arm) begin
            meter_phase = PH_DELAY;
            hold_count  = cfg_start_delay;
            tone_pos    = PULSE_SPAN;
            for (int c = 0; c < 4; c++) lane_live[c] = 1'b0;
            return r;
        end
        if (meter_phase == PH_DELAY) begin
            if (hold_count == 16'd0) begin
                meter_phase = PH_MEASURE;
                tone_pos    = 0;
                pulse_t0    = tick_count;
                for (int c = 0; c < 4; c++) begin
                    lane_live[c]    = (c < n);
                    lane_min[c]     = cfg_low;
                    lane_max[c]     = signed'({1'b0, cfg_high});
                    lane_tmin[c]    = '0;
                    lane_tmax[c]    = '0;
                    lane_has_min[c] = 1'b0;
                    lane_has_max[c] = 1'b0;
                end
            end else begin
                hold_count = hold_count - 16'd1;
            end
        end
        if (meter_phase == PH_MEASURE) begin
            all_quiet = 1'b1;
            if (tone_pos < PULSE_SPAN) begin
                r.tx     = 16'(SHAPE[tone_pos]);
                tone_pos = tone_pos + 1;
            end
            for (int c = 0; c < 4; c++) begin
                v = signed'(rx[c]);
                if (lane_live[c]) begin
                    // minimum wins over maximum, finish only when neither moved
                    if (v < lane_min[c]) begin
                        lane_min[c]     = v;
                        lane_tmin[c]    = tick_count;
                        lane_has_min[c] = 1'b1;
                    end else if (v > lane_max[c]) begin
                        lane_max[c]     = v;
                        lane_tmax[c]    = tick_count;
                        lane_has_max[c] = 1'b1;
                    end else if (lane_has_min[c] && lane_has_max[c]) begin
                        lane_live[c] = 1'b0;
                    end
                    if (lane_live[c]) all_quiet = 1'b0;
                end
            end
            if (all_quiet || (tick_count - pulse_t0) >= {15'd0, cfg_timeout}) begin
                r.done = 1'b1;
                for (int c = 0; c < 4; c++) begin
                    if (c < n && !lane_live[c] && lane_has_min[c] && lane_has_max[c]) begin
                        avg = ({1'b0, lane_tmin[c] - pulse_t0}
                             + {1'b0, lane_tmax[c] - pulse_t0}) >> 1;
                        r.mask[c] = 1'b1;
                        r.lat[c]  = avg[17:0] - 18'(PULSE_SPAN / 2);
                    end
                end
                meter_phase = PH_IDLE;
                tone_pos    = PULSE_SPAN;
                for (int c = 0; c < 4; c++) lane_live[c] = 1'b0;
            end
        end
        tick_count = tick_count + 32'd1;
        return r;
    endfunction

    // one input beat, with an optional idle burst in front of it
    task automatic send_beat(input logic arm, input logic [3:0][15:0] rx);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= arm;
        i_rx_sample_0 <= rx[0];
        i_rx_sample_1 <= rx[1];
        i_rx_sample_2 <= rx[2];
        i_rx_sample_3 <= rx[3];
        do @(posedge i_clk); while (o_stall);
        report_q.push_back(meter_advance(arm, rx));
        beats_in++;
    endtask

    task automatic tick4(input int a, input int b, input int c, input int d);
        send_beat(1'b0, {16'(d), 16'(c), 16'(b), 16'(a)});
    endtask

    task automatic arm_meter();
        send_beat(1'b1, {$urandom, $urandom});
    endtask

    // let the pipeline empty before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        logic [16:0] d;
        d = 17'(value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_DELAY: cfg_start_delay = d[15:0];
            CFG_TIMEOUT:     cfg_timeout     = d;
            CFG_LOW_TH:      cfg_low         = signed'(d[15:0]);
            CFG_HIGH_TH:     cfg_high        = d[14:0];
            CFG_CHANNELS:    cfg_chans       = d[2:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // received echo: scaled, maybe inverted pulse plus noise, saturated
    function automatic logic [15:0] echo_sample(input int j, input int gain, input bit flip,
                                                input int amp);
        int v;
        v = 0;
        if (j >= 0 && j < PULSE_SPAN) v = SHAPE[j] * gain / 8;
        if (flip) v = -v;
        if (amp > 0) v = v + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic run_episode();
        int               lag  [4];
        int               gain [4];
        bit               flip [4];
        int               amp;
        int               d;
        int               k;
        int               cut;
        logic [3:0][15:0] f;
        if ($urandom_range(0, 4) == 0) begin
            // noise: full-range samples with the odd stray arm
            repeat ($urandom_range(4, 30))
                send_beat($urandom_range(0, 15) == 0, {$urandom, $urandom});
            return;
        end
        for (int c = 0; c < 4; c++) begin
            lag[c]  = $urandom_range(0, 40);
            gain[c] = $urandom_range(1, 12);
            flip[c] = $urandom_range(0, 1);
        end
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1200) : $urandom_range(0, 200);
        repeat ($urandom_range(0, 2)) send_beat(1'b0, {$urandom, $urandom});
        arm_meter();
        d   = int'(cfg_start_delay);
        cut = d + 150;
        if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, cut);
        k = 0;
        while (k < cut && meter_phase != PH_IDLE) begin
            for (int c = 0; c < 4; c++) f[c] = echo_sample(k - d - lag[c], gain[c], flip[c], amp);
            send_beat(1'b0, f);
            k++;
        end
    endtask

    task automatic pick_random_setting();
        int r;
        r = $urandom_range(0, 7);
        write_reg(CFG_START_DELAY, (r == 0) ? 0 : (r == 7) ? $urandom_range(13, 60)
                                                           : $urandom_range(1, 12));
        r = $urandom_range(0, 9);
        write_reg(CFG_TIMEOUT, (r == 0) ? $urandom_range(0, 6) : (r == 1) ? 131071
                                                               : $urandom_range(50, 250));
        r = $urandom_range(0, 9);
        write_reg(CFG_LOW_TH, (r == 0) ? 0 : (r == 1) ? -32768 : -$urandom_range(100, 3000));
        r = $urandom_range(0, 9);
        write_reg(CFG_HIGH_TH, (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(100, 3000));
        r = $urandom_range(0, 9);
        write_reg(CFG_CHANNELS, (r == 0) ? $urandom_range(5, 7) : (r == 1) ? 0
                                                                : $urandom_range(1, 4));
    endtask

    // default registers: long delay, so only silence comes back
    task automatic test_after_reset();
        tick4(-32768, 32767, -32768, 32767);
        tick4(32767, -32768, 32767, -32768);
        arm_meter();
        repeat (3) tick4(-32768, 32767, 0, -1);
    endtask

    task automatic test_sample_extremes();
        write_reg(CFG_START_DELAY, 0);
        write_reg(CFG_TIMEOUT, 40);
        write_reg(CFG_LOW_TH, -328);
        write_reg(CFG_HIGH_TH, 328);
        write_reg(CFG_CHANNELS, 4);
        arm_meter();
        // samples equal to a threshold are not new extremes
        tick4(-32768, 32767, 0, -328);
        tick4(32767, -32768, 328, 329);
        tick4(0, 0, 0, -32768);
        tick4(0, 0, 0, 0);
        tick4(0, 0, -329, 0);
        tick4(0, 0, 329, 0);
        tick4(0, 0, 0, 0);
        tick4(32767, -32768, 32767, -32768);
        arm_meter();
        tick4(-1000, -1000, -1000, -1000);
        arm_meter();
        tick4(1000, 1000, 1000, 1000);
    endtask

    task automatic test_register_corners();
        // zero timeout ends on the pulse start tick
        write_reg(CFG_TIMEOUT, 0);
        arm_meter();
        tick4(-32768, 32767, -32768, 32767);
        // no channels: ends at once with an empty mask
        write_reg(CFG_TIMEOUT, 40);
        write_reg(CFG_CHANNELS, 0);
        arm_meter();
        tick4(-5000, 5000, -5000, 5000);
        // counts above four behave as four
        write_reg(CFG_CHANNELS, 7);
        arm_meter();
        tick4(-5000, -5000, -5000, -5000);
        tick4(5000, 5000, 5000, 5000);
        tick4(0, 0, 0, 0);
        write_reg(CFG_CHANNELS, 1);
        write_reg(CFG_LOW_TH, 0);
        write_reg(CFG_HIGH_TH, 0);
        arm_meter();
        tick4(-1, 1, -1, 1);
        tick4(1, -1, 1, -1);
        tick4(0, 0, 0, 0);
        // unreachable thresholds and a short timeout cut the pulse off
        write_reg(CFG_LOW_TH, -32768);
        write_reg(CFG_HIGH_TH, 32767);
        write_reg(CFG_TIMEOUT, 3);
        write_reg(CFG_CHANNELS, 4);
        arm_meter();
        repeat (5) tick4(-32768, 32767, -32768, 32767);
        write_reg(CFG_START_DELAY, 65535);
        arm_meter();
        repeat (3) tick4(-32768, 32767, 1, -1);
    endtask

    // sink holds off for a long stretch while beats keep coming
    task automatic test_output_holdoff();
        pick_random_setting();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_req     = 1'b1;
        repeat (2) run_episode();
    endtask

    task automatic test_random_sessions();
        while (beats_in < CALM_FROM) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            pick_random_setting();
            repeat ($urandom_range(3, 6)) run_episode();
        end
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (beats_in < TOTAL_BEATS) begin
            pick_random_setting();
            repeat (4) if (beats_in < TOTAL_BEATS) run_episode();
        end
    endtask

    // result sink: random stall bursts and the one long hold
    initial begin : sink_side
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report w;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (report_q.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatches++;
            end else begin
                w = report_q.pop_front();
                if (o_done_res === 1'b1) reports_done++;
                check_field("tx_sample",  {2'b0, w.tx},     {2'b0, o_tx_sample});
                check_field("done_res",   {17'b0, w.done},  {17'b0, o_done_res});
                check_field("found_mask", {14'b0, w.mask},  {14'b0, o_found_mask});
                check_field("latency_0",  w.lat[0],         o_latency_0);
                check_field("latency_1",  w.lat[1],         o_latency_1);
                check_field("latency_2",  w.lat[2],         o_latency_2);
                check_field("latency_3",  w.lat[3],         o_latency_3);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = 1'b0;
        i_rx_sample_0 = '0;
        i_rx_sample_1 = '0;
        i_rx_sample_2 = '0;
        i_rx_sample_3 = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        beats_in      = 0;
        beats_out     = 0;
        reports_done  = 0;
        reg_writes    = 0;
        mismatches    = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        hold_req      = 1'b0;
        meter_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_sample_extremes();
        test_register_corners();
        test_output_holdoff();
        test_random_sessions();

        settle();
        repeat (8) @(negedge i_clk);
        if (report_q.size() != 0) begin
            $error("%0d result beats never arrived", report_q.size());
            mismatches++;
        end
        $display("covered %0d sample and arm beats, %0d result beats checked",
                 beats_in, beats_out);
        $display("%0d measurements reported, %0d register writes, %0d mismatches",
                 reports_done, reg_writes, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/apl_pkg.sv
hdl/apl_lane.sv
hdl/apl_merge.sv
hdl/apl_seq.sv
hdl/audio_pulse_latency_meter.sv
tb/sv/tb.sv
